/* rtl/core/pbd_pkg.sv */
// pbd_pkg: shared types, constants and register indexes for the pulse beat detector
// no dependencies
package pbd_pkg;
   localparam int HISTORY_DEPTH_DEF = 10;
   localparam logic [15:0] BPM_NUMERATOR = 16'd60000;
   localparam logic [15:0] INTERVAL_RESET = 16'd600;

   localparam logic [2:0] REG_SAMPLE_STEP = 3'd0;
   localparam logic [2:0] REG_SEED_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_SEED_LEVEL = 3'd2;
   localparam logic [2:0] REG_MIN_GAP = 3'd3;
   localparam logic [2:0] REG_LOST_TIMEOUT = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture sample and run the beat step
      logic avg_start; // shift history and form the saturated sum
      logic div_start; // form the mean and start the rate divider
      logic div_step;  // one restoring division step
      logic finish;    // store rate, pulse end and timeout
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_rate; // the beat needs a new rate
      logic mean_zero; // mean is zero, rate saturates
      logic div_last;  // last division step
   } status_type;
endpackage

/* rtl/core/pbd_datapath.sv */
// pbd_datapath: beat detection state, history, and a restoring divider
// depends on pbd_pkg
module pbd_datapath import pbd_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [9:0]  sample,
   input  logic [7:0]  cfg_step,
   input  logic [9:0]  cfg_seed_threshold,
   input  logic [9:0]  cfg_seed_level,
   input  logic [15:0] cfg_min_gap,
   input  logic [15:0] cfg_lost_timeout,
   output logic        beat_found,
   output logic [15:0] beats_per_minute,
   output logic [15:0] interval_ms,
   output logic        pulse_active,
   output logic [9:0]  amplitude
);
   localparam int CNT_W = 4;
   // ceil(2^20 / depth): exact floor division for any 16-bit sum and depth from 2 up to 16
   localparam int RECIP = (2**20 + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
   localparam logic [19:0] RECIP20 = 20'(RECIP);
   localparam logic [19:0] DEPTH20 = 20'(HISTORY_DEPTH);
   logic [15:0] elapsed_ff, peak_ff, trough_ff, thr_ff;
   logic [9:0]  amp_ff;
   logic [15:0] interval_ff, rate_ff, sum_ff, mean_ff;
   logic        in_pulse_ff, first_ff, second_ff;
   logic        found_ff, need_ff, timeout_ff, first_skip_ff;
   logic [9:0]  s_ff;
   logic [15:0] n_ff;
   logic [15:0] hist_ff [HISTORY_DEPTH];
   logic [19:0] hist_total_ff;
   logic [15:0] quot_ff, rem_ff;
   logic [CNT_W-1:0] dcnt_ff;

   // combinational beat step on sample input
   logic [16:0] n_sum;
   logic [15:0] n, refr;
   logic [31:0] div5_prod;
   logic beat;
   always_comb begin
      n_sum = {1'b0, elapsed_ff} + {9'd0, cfg_step};
      n = n_sum[16] ? 16'hFFFF : n_sum[15:0];
      // interval / 5 by reciprocal 52429 / 2^18, exact for 16-bit values
      div5_prod = {16'd0, interval_ff} * 32'd52429;
      refr = 16'({2'd0, div5_prod[31:18]} * 16'd3);
      beat = (n > cfg_min_gap) && ({6'd0, sample} > {6'd0, thr_ff[9:0]}) && !in_pulse_ff
             && (n > refr);
   end

   // sum of the shifted history from the running total, saturated
   logic [19:0] hsum;
   logic [15:0] hsum_sat;
   always_comb begin
      hsum = hist_total_ff - {4'd0, hist_ff[0]} + {4'd0, n_ff};
      hsum_sat = (hsum > 20'hFFFF) ? 16'hFFFF : hsum[15:0];
   end

   // mean by reciprocal multiplication
   logic [35:0] mean_prod;
   always_comb mean_prod = {20'd0, sum_ff} * {16'd0, RECIP20};

   // restoring divider step
   logic [16:0] trial;
   always_comb trial = {rem_ff, quot_ff[15]} - {1'b0, mean_ff};

   // pulse end and timeout, applied in finish
   logic [9:0] amp_c, thr_c;
   logic pulse_end;
   always_comb begin
      amp_c = (peak_ff[9:0] >= trough_ff[9:0]) ? peak_ff[9:0] - trough_ff[9:0] : 10'd0;
      thr_c = 10'((amp_c >> 1) + trough_ff[9:0]);
      pulse_end = ({6'd0, s_ff} < thr_ff) && in_pulse_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= 16'd0; peak_ff <= 16'd512; trough_ff <= 16'd512;
         thr_ff <= 16'd530; interval_ff <= INTERVAL_RESET; amp_ff <= 10'd0;
         in_pulse_ff <= 1'b0; first_ff <= 1'b1; second_ff <= 1'b0;
         rate_ff <= 16'd0; found_ff <= 1'b0; need_ff <= 1'b0;
         timeout_ff <= 1'b0; dcnt_ff <= '0; hist_total_ff <= 20'd0;
      end else begin
         if (cmd.load) begin
            s_ff <= sample;
            n_ff <= n;
            timeout_ff <= n > cfg_lost_timeout;
            elapsed_ff <= beat ? 16'd0 : n;
            found_ff <= 1'b0;
            need_ff <= beat && !first_ff;
            if ({6'd0, sample} < thr_ff && n > refr && {6'd0, sample} < trough_ff)
               trough_ff <= {6'd0, sample};
            if ({6'd0, sample} > thr_ff && {6'd0, sample} > peak_ff)
               peak_ff <= {6'd0, sample};
            if (beat) begin
               in_pulse_ff <= 1'b1;
               interval_ff <= n;
               if (second_ff) begin
                  second_ff <= 1'b0;
                  for (int i = 0; i < HISTORY_DEPTH; i++) hist_ff[i] <= n;
                  hist_total_ff <= {4'd0, n} * DEPTH20;
               end
               if (first_ff) begin
                  first_ff <= 1'b0; second_ff <= 1'b1;
               end
            end
         end
         if (cmd.avg_start) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist_ff[i] <= hist_ff[i+1];
            hist_ff[HISTORY_DEPTH-1] <= n_ff;
            hist_total_ff <= hsum;
            sum_ff <= hsum_sat;
         end
         if (cmd.div_start) begin
            mean_ff <= mean_prod[35:20];
            quot_ff <= BPM_NUMERATOR; rem_ff <= 16'd0; dcnt_ff <= '0;
         end
         if (cmd.div_step) begin
            dcnt_ff <= dcnt_ff + 1'b1;
            if (!trial[16]) begin
               rem_ff <= trial[15:0]; quot_ff <= {quot_ff[14:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[14:0], quot_ff[15]}; quot_ff <= {quot_ff[14:0], 1'b0};
            end
         end
         if (cmd.finish) begin
            if (need_ff) begin
               found_ff <= 1'b1;
               rate_ff <= (mean_ff == 16'd0) ? BPM_NUMERATOR : quot_ff;
            end
            // first beat exits early, skipping pulse end and timeout
            if (!first_skip_ff) begin
               if (pulse_end) begin
                  in_pulse_ff <= 1'b0;
                  amp_ff <= amp_c;
               end
               // timeout reseed wins over the pulse end threshold move
               if (timeout_ff) begin
                  thr_ff <= {6'd0, cfg_seed_threshold};
                  peak_ff <= {6'd0, cfg_seed_level}; trough_ff <= {6'd0, cfg_seed_level};
                  elapsed_ff <= 16'd0; first_ff <= 1'b1; second_ff <= 1'b0;
               end else if (pulse_end) begin
                  thr_ff <= {6'd0, thr_c}; peak_ff <= {6'd0, thr_c}; trough_ff <= {6'd0, thr_c};
               end
            end
         end
      end
   end

   // marks a first-beat sample at load time
   always_ff @(posedge clock) begin
      if (reset) first_skip_ff <= 1'b0;
      else if (cmd.load) first_skip_ff <= beat && first_ff;
   end

   assign status.need_rate = need_ff;
   assign status.mean_zero = (mean_ff == 16'd0);
   assign status.div_last = (dcnt_ff == CNT_W'(15));
   assign beat_found = found_ff;
   assign beats_per_minute = rate_ff;
   assign interval_ms = interval_ff;
   assign pulse_active = in_pulse_ff;
   assign amplitude = amp_ff;
endmodule

/* rtl/core/pbd_controller.sv */
// pbd_controller: sequencer for load, averaging, division and result
// depends on pbd_pkg
module pbd_controller import pbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_AVG = 3'd2;
   localparam logic [2:0] ST_DIV = 3'd3;
   localparam logic [2:0] ST_FIN = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;
   localparam logic [2:0] ST_MEAN = 3'd6;
   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) begin cmd.load = 1'b1; state_in = ST_CHECK; end
         ST_CHECK: state_in = status.need_rate ? ST_AVG : ST_FIN;
         ST_AVG: begin cmd.avg_start = 1'b1; state_in = ST_MEAN; end
         ST_MEAN: begin cmd.div_start = 1'b1; state_in = ST_DIV; end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin cmd.finish = 1'b1; state_in = ST_OUT; end
         ST_OUT: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   logic unused;
   assign unused = status.mean_zero;

   a_out_after_fin: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |=> rsp_tvalid) else $error("no result after finish");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("accept while result pending");
endmodule

/* rtl/core/pulse_beat_detector_unit.sv */
// pulse_beat_detector_unit: top level of the pulse beat detector
// depends on pbd_pkg, pbd_controller, pbd_datapath
//
// channel | direction | contents
// req     | in        | tdata[9:0] sample
// rsp     | out       | tdata: beat_found, beats_per_minute, interval_ms, pulse_active, amplitude
// csr     | in        | index, data
//
// a sample without a new rate (including a first beat) passes through check and finish to the
// result; a beat with a new rate also passes through sum, mean and the 16-step restoring
// divider for 60000 / mean before finish
// one sample in flight; the next is accepted the cycle after the result is taken
// reset is synchronous, active high, and restores all but sample, history and divider registers
module pulse_beat_detector_unit import pbd_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // sample[9:0], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // beat_found, beats_per_minute, interval_ms, pulse_active,
                                   // amplitude, zeros
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic [7:0] step_ff;
   logic [9:0] seed_thr_ff, seed_lvl_ff;
   logic [15:0] gap_ff, lost_ff;
   cmd_type cmd;
   status_type status;
   logic bf, pa;
   logic [15:0] bpm, ivl;
   logic [9:0] amp;

   assign csr_ready = 1'b1;
   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 8'd2; seed_thr_ff <= 10'd530; seed_lvl_ff <= 10'd512;
         gap_ff <= 16'd250; lost_ff <= 16'd2500;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SAMPLE_STEP: step_ff <= csr_data[7:0];
            REG_SEED_THRESHOLD: seed_thr_ff <= csr_data[9:0];
            REG_SEED_LEVEL: seed_lvl_ff <= csr_data[9:0];
            REG_MIN_GAP: gap_ff <= csr_data;
            REG_LOST_TIMEOUT: lost_ff <= csr_data;
            default: ;
         endcase
      end
   end

   pbd_controller u_ctrl (.clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid,
      .rsp_tready, .cmd, .status);

   pbd_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (.clock, .reset, .cmd, .status,
      .sample(req_tdata[9:0]), .cfg_step(step_ff), .cfg_seed_threshold(seed_thr_ff),
      .cfg_seed_level(seed_lvl_ff), .cfg_min_gap(gap_ff), .cfg_lost_timeout(lost_ff),
      .beat_found(bf), .beats_per_minute(bpm), .interval_ms(ivl), .pulse_active(pa),
      .amplitude(amp));

   assign rsp_tdata = {4'd0, amp, pa, ivl, bpm, bf};
endmodule
